// ----- rtl/mwm_pkg.sv -----
// mwm_pkg: shared constants and types for the mecanum wheel mixer
// sine polynomial coefficients, divide-by-255 reciprocal, register indexes
// no dependencies
`timescale 1ns / 1ps

package mwm_pkg;

   // taylor coefficients of sin(pi/2*x), q30
   localparam logic [31:0] SIN_A1 = 32'd1686629713;
   localparam logic [31:0] SIN_A3 = 32'd693598668;
   localparam logic [31:0] SIN_A5 = 32'd85569306;
   localparam logic [31:0] SIN_A7 = 32'd5026995;
   localparam logic [31:0] SIN_A9 = 32'd172272;

   // register stages of the sine pipeline
   localparam int SINE_STAGES = 8;

   // floor(t / 255) = (t * RECIP_255) >> RECIP_SHIFT, exact for t < 2^18
   localparam logic [18:0] RECIP_255   = 19'd263173;
   localparam int          RECIP_SHIFT = 26;

   localparam logic [8:0] WHEEL_MAX = 9'd511;

   typedef enum logic [1:0] {
      REG_ROT_CORR_MIN  = 2'd0,
      REG_ROT_CORR_MAX  = 2'd1,
      REG_DRIVE_ENABLED = 2'd2,
      REG_GYRO_ENABLED  = 2'd3
   } csr_index_type;

endpackage

// ----- rtl/mecanum_wheel_mixer.sv -----
// mecanum_wheel_mixer: top level of the mecanum drive inverse kinematics
// input conditioning, two sine pipelines, wheel mixing and rounding, csr port
// depends on mwm_pkg and mwm_sine
`timescale 1ns / 1ps

// Usage
// A command transaction on the req_ channel (drive speed, heading angle,
// rotation correction) gives one result transaction on the rsp_ channel
// with the four signed wheel speeds. A transaction moves at a rising edge
// where valid is high and stall is low.
// The block is an 11-stage pipeline that takes one command every cycle
// unless req_stall is high. The depth is set by the sine path: a fold, a
// squaring, five 32-bit horner multiplies and a rounding stage, then the
// wheel multiply, a round and divide-by-2^(F+1) stage and the output
// register that divides by 255.
// When rsp_stall is high, stages holding data keep it and empty stages in
// front of them still fill, so req_stall rises only once the pipeline is
// full. Nothing is dropped or repeated.
// Reset empties the pipeline and loads the registers with their defaults:
// limits -255 and 255, drive and gyro enabled.
// The csr_ port is APB-like, registers at byte addresses 0, 4, 8 and 12;
// it should be written only while the pipeline is empty.

module mecanum_wheel_mixer
   import mwm_pkg::*;
#(
   parameter int ANGLE_BITS     = 16,
   parameter int SINE_FRAC_BITS = 15
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [15:0]        req_drive_speed,
   input  logic signed [15:0] req_heading_angle,
   input  logic signed [15:0] req_rot_correction,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [9:0]  rsp_front_left_speed,
   output logic signed [9:0]  rsp_front_right_speed,
   output logic signed [9:0]  rsp_back_left_speed,
   output logic signed [9:0]  rsp_back_right_speed,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int AB   = ANGLE_BITS;
   localparam int F    = SINE_FRAC_BITS;
   localparam int NSTG = SINE_STAGES + 3;
   localparam int SW   = F + 2;
   localparam int BW   = F + 17;
   localparam int PW   = F + 21;
   localparam int NW   = F + 22;
   localparam logic [AB-1:0] EIGHTH = AB'(1) << (AB - 3);
   localparam logic [NW:0]   HALF_DEN = (NW+1)'(255) << F;

   // configuration registers
   logic signed [8:0] rot_min_ff;
   logic [7:0]        rot_max_ff;
   logic              drive_en_ff;
   logic              gyro_en_ff;
   csr_index_type     csr_index;

   assign csr_index  = csr_index_type'(csr_paddr[3:2]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_min_ff  <= -9'sd255;
         rot_max_ff  <= 8'd255;
         drive_en_ff <= 1'b1;
         gyro_en_ff  <= 1'b1;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_index)
            REG_ROT_CORR_MIN:  rot_min_ff  <= $signed(csr_pwdata[8:0]);
            REG_ROT_CORR_MAX:  rot_max_ff  <= csr_pwdata[7:0];
            REG_DRIVE_ENABLED: drive_en_ff <= csr_pwdata[0];
            REG_GYRO_ENABLED:  gyro_en_ff  <= csr_pwdata[0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_ROT_CORR_MIN:  csr_prdata = 32'($signed(rot_min_ff));
         REG_ROT_CORR_MAX:  csr_prdata = {24'd0, rot_max_ff};
         REG_DRIVE_ENABLED: csr_prdata = {31'd0, drive_en_ff};
         REG_GYRO_ENABLED:  csr_prdata = {31'd0, gyro_en_ff};
      endcase
   end

   // pipeline control: a stage loads when it is empty or its data moves on
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] vld_in;
   logic [NSTG-1:0] en;

   always_comb begin
      en[NSTG-1] = !vld_ff[NSTG-1] || !rsp_stall;
      for (int i = NSTG - 2; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
      vld_in[0] = en[0] ? req_valid : vld_ff[0];
      for (int i = 1; i < NSTG; i++) begin
         vld_in[i] = en[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = vld_ff[NSTG-1];

   // stage 0: saturate speed, clamp correction (zero when gyro is off), form sine phases
   logic [7:0]        s_ff;
   logic [7:0]        s_in;
   logic signed [8:0] d_ff;
   logic signed [8:0] d_in;
   logic [AB-1:0]     phase_a;
   logic [AB-1:0]     phase_b;

   always_comb begin
      logic [AB+15:0] wide;
      wide    = {req_heading_angle, {AB{1'b0}}};
      phase_a = wide[AB+15:16] + EIGHTH;
      phase_b = EIGHTH - wide[AB+15:16];
      s_in = (req_drive_speed > 16'd255) ? 8'd255 : req_drive_speed[7:0];
      d_in = 9'sd0;
      if (gyro_en_ff) begin
         if (req_rot_correction < 16'(rot_min_ff)) begin
            d_in = rot_min_ff;
         end else if (req_rot_correction > $signed({8'd0, rot_max_ff})) begin
            d_in = $signed({1'b0, rot_max_ff});
         end else begin
            d_in = req_rot_correction[8:0];
         end
      end
   end

   logic signed [SW-1:0] sa;
   logic signed [SW-1:0] sb;

   mwm_sine #(
      .ANGLE_BITS     (ANGLE_BITS),
      .SINE_FRAC_BITS (SINE_FRAC_BITS)
   ) u_sine_a (
      .clock (clock),
      .en    (en[SINE_STAGES-1:0]),
      .phase (phase_a),
      .sine  (sa)
   );

   mwm_sine #(
      .ANGLE_BITS     (ANGLE_BITS),
      .SINE_FRAC_BITS (SINE_FRAC_BITS)
   ) u_sine_b (
      .clock (clock),
      .en    (en[SINE_STAGES-1:0]),
      .phase (phase_b),
      .sine  (sb)
   );

   // stage 1: k = s * (510 - d), base = d * 255 * 2^F
   logic [17:0]          k_ff [1:SINE_STAGES-1];
   logic [17:0]          k_in;
   logic signed [BW-1:0] base_ff [1:SINE_STAGES];
   logic signed [BW-1:0] base_in;
   logic                 drv_ff [0:NSTG-2];

   always_comb begin
      logic signed [10:0] diff;
      logic signed [16:0] d255;
      diff    = 11'sd510 - 11'(d_ff);
      k_in    = 18'(s_ff) * 18'(diff[9:0]);
      d255    = 17'(d_ff) * 17'sd255;
      base_in = $signed({d255, {F{1'b0}}});
   end

   // stage SINE_STAGES: signed products k * sine
   logic signed [PW-1:0] pa_ff;
   logic signed [PW-1:0] pb_ff;
   logic signed [PW-1:0] pa_in;
   logic signed [PW-1:0] pb_in;

   assign pa_in = PW'($signed({1'b0, k_ff[SINE_STAGES-1]})) * PW'(sa);
   assign pb_in = PW'($signed({1'b0, k_ff[SINE_STAGES-1]})) * PW'(sb);

   // next stage: round half away from zero and divide by 2^(F+1)
   logic [17:0] t_ff [0:3];
   logic [17:0] t_in [0:3];
   logic        neg_ff [0:3];
   logic        neg_in [0:3];

   always_comb begin
      logic signed [NW-1:0] n [0:3];
      logic [NW-1:0]        mag;
      logic [NW:0]          tsum;
      n[0] = -NW'(pa_ff) - NW'(base_ff[SINE_STAGES]);
      n[1] =  NW'(pb_ff) - NW'(base_ff[SINE_STAGES]);
      n[2] = -NW'(pb_ff) - NW'(base_ff[SINE_STAGES]);
      n[3] =  NW'(pa_ff) - NW'(base_ff[SINE_STAGES]);
      for (int w = 0; w < 4; w++) begin
         neg_in[w] = n[w][NW-1];
         mag       = neg_in[w] ? NW'(-n[w]) : NW'(n[w]);
         tsum      = (NW+1)'(mag) + HALF_DEN;
         t_in[w]   = tsum[F+18:F+1];
      end
   end

   // output stage: divide by 255, saturate, sign, drive gate
   logic signed [9:0] out_ff [0:3];
   logic signed [9:0] out_in [0:3];

   always_comb begin
      logic [36:0] qp;
      logic [10:0] q;
      logic [8:0]  qs;
      for (int w = 0; w < 4; w++) begin
         qp = 37'(t_ff[w]) * 37'(RECIP_255);
         q  = qp[RECIP_SHIFT+10:RECIP_SHIFT];
         qs = (q > 11'(WHEEL_MAX)) ? WHEEL_MAX : q[8:0];
         if (!drv_ff[NSTG-2]) begin
            out_in[w] = 10'sd0;
         end else if (neg_ff[w]) begin
            out_in[w] = -$signed({1'b0, qs});
         end else begin
            out_in[w] = $signed({1'b0, qs});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s_ff      <= s_in;
         d_ff      <= d_in;
         drv_ff[0] <= drive_en_ff;
      end
      if (en[1]) begin
         k_ff[1]    <= k_in;
         base_ff[1] <= base_in;
      end
      for (int i = 2; i < SINE_STAGES; i++) begin
         if (en[i]) begin
            k_ff[i]    <= k_ff[i-1];
            base_ff[i] <= base_ff[i-1];
         end
      end
      for (int i = 1; i < NSTG - 1; i++) begin
         if (en[i]) begin
            drv_ff[i] <= drv_ff[i-1];
         end
      end
      if (en[SINE_STAGES]) begin
         pa_ff                <= pa_in;
         pb_ff                <= pb_in;
         base_ff[SINE_STAGES] <= base_ff[SINE_STAGES-1];
      end
      if (en[SINE_STAGES+1]) begin
         for (int w = 0; w < 4; w++) begin
            t_ff[w]   <= t_in[w];
            neg_ff[w] <= neg_in[w];
         end
      end
      if (en[NSTG-1]) begin
         for (int w = 0; w < 4; w++) begin
            out_ff[w] <= out_in[w];
         end
      end
   end

   assign rsp_front_left_speed  = out_ff[0];
   assign rsp_front_right_speed = out_ff[1];
   assign rsp_back_left_speed   = out_ff[2];
   assign rsp_back_right_speed  = out_ff[3];

endmodule

// ----- rtl/mwm_sine.sv -----
// mwm_sine: pipelined fixed-point sine of a binary angle
// quarter-wave fold, five q30 horner steps, rounding to signed q(frac)
// depends on mwm_pkg
`timescale 1ns / 1ps

module mwm_sine
   import mwm_pkg::*;
#(
   parameter int ANGLE_BITS     = 16,
   parameter int SINE_FRAC_BITS = 15
) (
   input  logic                             clock,
   input  logic [SINE_STAGES-1:0]           en,
   input  logic [ANGLE_BITS-1:0]            phase,
   output logic signed [SINE_FRAC_BITS+1:0] sine
);

   localparam int AB = ANGLE_BITS;
   localparam int F  = SINE_FRAC_BITS;
   localparam logic [AB-2:0] QUARTER = (AB-1)'(1) << (AB - 2);
   localparam logic [32:0]   RND_HALF = 33'd1 << (29 - F);
   localparam logic [F+2:0]  ONE_Q = (F+3)'(1) << F;

   logic [30:0] x_ff [0:5];
   logic [30:0] x_in;
   logic [30:0] x2_ff [1:4];
   logic [30:0] x2_in;
   logic [31:0] p_ff [2:5];
   logic [31:0] p_in [2:5];
   logic [31:0] px_ff;
   logic [31:0] px_in;
   logic        neg_ff [0:6];
   logic signed [F+1:0] sine_ff;
   logic signed [F+1:0] sine_in;

   // stage 0: fold onto a quarter wave
   always_comb begin
      logic [AB-3:0] r;
      logic [AB-2:0] pos;
      r   = phase[AB-3:0];
      pos = phase[AB-2] ? QUARTER - {1'b0, r} : {1'b0, r};
      x_in = {pos, {(32 - AB){1'b0}}};
   end

   // stages 1 to 6: square, horner steps, final multiply by x
   always_comb begin
      logic [63:0] prod2;
      logic [63:0] prod [3:5];
      logic [63:0] prodx;
      logic [63:0] sq;
      sq    = 64'(x_ff[0]) * 64'(x_ff[0]);
      x2_in = sq[60:30];
      prod2 = 64'(SIN_A9) * 64'(x2_ff[1]);
      p_in[2] = SIN_A7 - prod2[61:30];
      for (int j = 3; j <= 5; j++) begin
         prod[j] = 64'(p_ff[j-1]) * 64'(x2_ff[j-1]);
      end
      p_in[3] = SIN_A5 - prod[3][61:30];
      p_in[4] = SIN_A3 - prod[4][61:30];
      p_in[5] = SIN_A1 - prod[5][61:30];
      prodx = 64'(p_ff[5]) * 64'(x_ff[5]);
      px_in = prodx[61:30];
   end

   // stage 7: round, cap at one, apply sign
   always_comb begin
      logic [32:0]  rnd;
      logic [F+2:0] v;
      logic [F+1:0] mag;
      rnd = 33'(px_ff) + RND_HALF;
      v   = rnd[32:30-F];
      if (v > ONE_Q) begin
         v = ONE_Q;
      end
      mag = v[F+1:0];
      sine_in = neg_ff[6] ? -$signed(mag) : $signed(mag);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         x_ff[0]   <= x_in;
         neg_ff[0] <= phase[AB-1];
      end
      if (en[1]) begin
         x_ff[1]   <= x_ff[0];
         x2_ff[1]  <= x2_in;
         neg_ff[1] <= neg_ff[0];
      end
      for (int j = 2; j <= 5; j++) begin
         if (en[j]) begin
            x_ff[j]   <= x_ff[j-1];
            p_ff[j]   <= p_in[j];
            neg_ff[j] <= neg_ff[j-1];
         end
      end
      // x squared is last needed by the stage 5 horner step
      for (int j = 2; j <= 4; j++) begin
         if (en[j]) begin
            x2_ff[j] <= x2_ff[j-1];
         end
      end
      if (en[6]) begin
         px_ff     <= px_in;
         neg_ff[6] <= neg_ff[5];
      end
      if (en[7]) begin
         sine_ff <= sine_in;
      end
   end

   assign sine = sine_ff;

endmodule

// ----- tb/mecanum_wheel_mixer_test.sv -----
// mecanum_wheel_mixer_test: self-checking testbench for the mecanum wheel mixer
// predicts four wheel speeds per command transaction and checks them in order
// depends on mwm_pkg and the mecanum_wheel_mixer rtl
`timescale 1ns / 1ps

module mecanum_wheel_mixer_test;
   import mwm_pkg::*;

   localparam int  IDLE_LIMIT  = 2000;
   localparam int  TAIL_CYCLES = 24;
   localparam int  ANGLE_W     = 16;
   localparam int  FRAC_W      = 15;
   localparam longint WHEEL_DEN = 510 * (64'sd1 <<< FRAC_W);

   typedef struct packed {
      logic signed [9:0] fl;
      logic signed [9:0] fr;
      logic signed [9:0] bl;
      logic signed [9:0] br;
   } wheel_set_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [15:0]        req_drive_speed;
   logic signed [15:0] req_heading_angle;
   logic signed [15:0] req_rot_correction;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [9:0]  rsp_front_left_speed;
   logic signed [9:0]  rsp_front_right_speed;
   logic signed [9:0]  rsp_back_left_speed;
   logic signed [9:0]  rsp_back_right_speed;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [3:0]         csr_paddr;
   logic [31:0]        csr_pwdata;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   // shadow copy of the block's registers
   logic signed [8:0]  corr_floor;
   logic [7:0]         corr_ceiling;
   bit                 drive_on;
   bit                 gyro_on;

   wheel_set_type      expected_wheels[$];
   int                 failures;
   int                 reported;
   int                 idle_cycles;
   int                 stall_left;
   bit                 sender_gaps;
   bit                 sink_stalls;

   mecanum_wheel_mixer uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_drive_speed       (req_drive_speed),
      .req_heading_angle     (req_heading_angle),
      .req_rot_correction    (req_rot_correction),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_front_left_speed  (rsp_front_left_speed),
      .rsp_front_right_speed (rsp_front_right_speed),
      .rsp_back_left_speed   (rsp_back_left_speed),
      .rsp_back_right_speed  (rsp_back_right_speed),
      .csr_psel              (csr_psel),
      .csr_penable           (csr_penable),
      .csr_pwrite            (csr_pwrite),
      .csr_paddr             (csr_paddr),
      .csr_pwdata            (csr_pwdata),
      .csr_prdata            (csr_prdata),
      .csr_pready            (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // quarter-wave folded polynomial sine, signed q15
   function automatic longint sine_q15(logic [ANGLE_W-1:0] phase);
      logic [1:0]  quad;
      logic [63:0] offs;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] acc;
      logic [63:0] mag;
      quad = phase[ANGLE_W-1 -: 2];
      offs = 64'(phase[ANGLE_W-3:0]);
      if (quad[0]) begin
         offs = (64'd1 << (ANGLE_W - 2)) - offs;
      end
      x   = offs << (32 - ANGLE_W);
      x2  = (x * x) >> 30;
      acc = 64'(SIN_A9);
      acc = 64'(SIN_A7) - ((acc * x2) >> 30);
      acc = 64'(SIN_A5) - ((acc * x2) >> 30);
      acc = 64'(SIN_A3) - ((acc * x2) >> 30);
      acc = 64'(SIN_A1) - ((acc * x2) >> 30);
      acc = (acc * x) >> 30;
      mag = (acc + (64'd1 << (29 - FRAC_W))) >> (30 - FRAC_W);
      if (mag > (64'd1 << FRAC_W)) begin
         mag = 64'd1 << FRAC_W;
      end
      return quad[1] ? -longint'(mag) : longint'(mag);
   endfunction

   // divide by the common denominator, half away from zero, then saturate
   function automatic logic signed [9:0] round_wheel(longint num);
      longint w;
      if (num >= 0) begin
         w = (num + WHEEL_DEN / 2) / WHEEL_DEN;
      end else begin
         w = -((-num + WHEEL_DEN / 2) / WHEEL_DEN);
      end
      if (w > 511) w = 511;
      if (w < -511) w = -511;
      return w[9:0];
   endfunction

   function automatic wheel_set_type mix_wheels(logic [15:0] speed,
                                                logic signed [15:0] heading,
                                                logic signed [15:0] rot);
      wheel_set_type      res;
      longint             s;
      longint             d;
      longint             lo;
      longint             hi;
      longint             k;
      longint             base;
      longint             sa;
      longint             sb;
      logic [ANGLE_W-1:0] eighth;
      res    = '0;
      eighth = 16'd1 << (ANGLE_W - 3);
      if (drive_on) begin
         s = speed;
         if (s > 255) s = 255;
         d = 0;
         if (gyro_on) begin
            lo = corr_floor;
            hi = corr_ceiling;
            d  = rot;
            if (d < lo) d = lo;
            else if (d > hi) d = hi;
         end
         sa     = sine_q15(heading + eighth);
         sb     = sine_q15(eighth - heading);
         k      = s * (510 - d);
         base   = d * 255 * (64'sd1 <<< FRAC_W);
         res.fl = round_wheel(-k * sa - base);
         res.fr = round_wheel(k * sb - base);
         res.bl = round_wheel(-k * sb - base);
         res.br = round_wheel(k * sa - base);
      end
      return res;
   endfunction

   task automatic send_command(logic [15:0] speed, logic signed [15:0] heading,
                               logic signed [15:0] rot);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_drive_speed    <= speed;
      req_heading_angle  <= heading;
      req_rot_correction <= rot;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_wheels.push_back(mix_wheels(speed, heading, rot));
   endtask

   task automatic send_random(bit wild_rot);
      logic [15:0] speed;
      logic [15:0] rot;
      case ($urandom_range(0, 3))
         0: speed = 16'($urandom);
         1: speed = 16'($urandom_range(250, 260));
         default: speed = 16'($urandom_range(0, 300));
      endcase
      if (wild_rot || $urandom_range(0, 3) == 0) begin
         rot = 16'($urandom);
      end else begin
         rot = 16'($urandom_range(0, 600) - 300);
      end
      send_command(speed, 16'($urandom), rot);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_wheels.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_ROT_CORR_MIN:  corr_floor   = value[8:0];
         REG_ROT_CORR_MAX:  corr_ceiling = value[7:0];
         REG_DRIVE_ENABLED: drive_on     = value[0];
         REG_GYRO_ENABLED:  gyro_on      = value[0];
         default: ;
      endcase
   endtask

   task automatic set_limits(int lo, int hi);
      write_register(REG_ROT_CORR_MIN, 32'(lo));
      write_register(REG_ROT_CORR_MAX, 32'(hi));
   endtask

   // field extremes, the four quadrant boundaries, clamp edges
   task automatic test_directed();
      send_command(16'd0, 16'sd0, 16'sd0);
      send_command(16'd255, 16'sd0, 16'sd0);
      send_command(16'd256, 16'sd8192, 16'sd0);
      send_command(16'hFFFF, 16'sd16384, 16'sd0);
      send_command(16'd1, -16'sd16384, 16'sd0);
      send_command(16'd255, -16'sd32768, 16'sd0);
      send_command(16'd255, 16'sd32767, 16'sd0);
      send_command(16'd255, -16'sd8192, 16'sd0);
      send_command(16'd200, 16'sd24576, 16'sd255);
      send_command(16'd200, -16'sd24576, -16'sd255);
      send_command(16'd255, 16'sd8192, 16'sd32767);
      send_command(16'd255, 16'sd8192, -16'sd32768);
      send_command(16'd255, 16'sd1, 16'sd1);
      send_command(16'd255, -16'sd1, -16'sd1);
      send_command(16'd0, 16'sd4096, 16'sd300);
      send_command(16'd0, 16'sd4096, -16'sd300);
      send_command(16'h8000, 16'h5555, 16'hAAAA);
      send_command(16'h7FFF, 16'hAAAA, 16'h5555);
      send_command(16'd128, 16'sd12345, 16'sd77);
      send_command(16'd255, 16'sd1, -16'sd3);
   endtask

   task automatic test_drive_disabled();
      wait_drained();
      write_register(REG_DRIVE_ENABLED, 32'd0);
      repeat (20) send_random(1'b1);
      wait_drained();
      write_register(REG_DRIVE_ENABLED, 32'd1);
   endtask

   task automatic test_gyro_disabled();
      wait_drained();
      write_register(REG_GYRO_ENABLED, 32'd0);
      send_command(16'd255, 16'sd0, 16'sd32767);
      send_command(16'd255, 16'sd0, -16'sd32768);
      repeat (28) send_random(1'b1);
      wait_drained();
      write_register(REG_GYRO_ENABLED, 32'd1);
   endtask

   // lower limit above upper, then the most negative lower limit
   task automatic test_crossed_limits();
      wait_drained();
      set_limits(100, 20);
      send_command(16'd255, 16'sd0, 16'sd50);
      send_command(16'd255, 16'sd0, 16'sd150);
      repeat (20) send_random(1'b0);
      wait_drained();
      set_limits(255, 0);
      repeat (10) send_random(1'b0);
      wait_drained();
      set_limits(-256, 255);
      send_command(16'd255, 16'sd8192, -16'sd32768);
      send_command(16'd255, -16'sd24576, -16'sd32768);
      repeat (10) send_random(1'b1);
   endtask

   task automatic test_drain_pause();
      repeat (20) send_random(1'b0);
      wait_drained();
      repeat (20) send_random(1'b0);
   endtask

   task automatic test_random_limits();
      int lo;
      int hi;
      for (int phase = 0; phase < 9; phase++) begin
         case (phase)
            0: begin lo = -255; hi = 255; end
            1: begin lo = 0; hi = 0; end
            2: begin lo = -255; hi = 0; end
            3: begin lo = 0; hi = 255; end
            default: begin
               lo = -int'($urandom_range(0, 255));
               hi = $urandom_range(0, 255);
            end
         endcase
         wait_drained();
         set_limits(lo, hi);
         sender_gaps = (phase % 3) != 2;
         sink_stalls = (phase % 4) != 3;
         repeat (60) send_random(phase[0]);
      end
   endtask

   task automatic test_steady_tail();
      wait_drained();
      set_limits(-255, 255);
      sender_gaps = 1'b0;
      sink_stalls = 1'b0;
      repeat (60) send_random(1'b0);
   endtask

   // result side: random stall bursts and in-order comparison
   task automatic note_mismatch(string field, logic signed [9:0] exp_v,
                                logic signed [9:0] got_v);
      failures++;
      if (reported < 10) begin
         reported++;
         $display("mismatch on %s: expected %0d, got %0d at %0t",
                  field, exp_v, got_v, $realtime);
      end
   endtask

   always @(posedge clock) begin
      wheel_set_type want;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_wheels.size() == 0) begin
               failures++;
               if (reported < 10) begin
                  reported++;
                  $display("result transaction with no command pending at %0t", $realtime);
               end
            end else begin
               want = expected_wheels.pop_front();
               if (rsp_front_left_speed !== want.fl)
                  note_mismatch("front_left_speed", want.fl, rsp_front_left_speed);
               if (rsp_front_right_speed !== want.fr)
                  note_mismatch("front_right_speed", want.fr, rsp_front_right_speed);
               if (rsp_back_left_speed !== want.bl)
                  note_mismatch("back_left_speed", want.bl, rsp_back_left_speed);
               if (rsp_back_right_speed !== want.br)
                  note_mismatch("back_right_speed", want.br, rsp_back_right_speed);
            end
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
            rsp_stall  <= 1'b1;
            stall_left = $urandom_range(0, 3);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog on cycles where no transaction or register access happens
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      failures           = 0;
      reported           = 0;
      idle_cycles        = 0;
      stall_left         = 0;
      sender_gaps        = 1'b1;
      sink_stalls        = 1'b1;
      corr_floor         = -9'sd255;
      corr_ceiling       = 8'd255;
      drive_on           = 1'b1;
      gyro_on            = 1'b1;
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_drive_speed    <= '0;
      req_heading_angle  <= '0;
      req_rot_correction <= '0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_drive_disabled();
      test_gyro_disabled();
      test_crossed_limits();
      test_drain_pause();
      test_random_limits();
      test_steady_tail();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      failures += expected_wheels.size();
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
